/* rtl/asfd_pkg.sv */
// shared widths, reset values, register indexes and types of the slicer frame decoder
// no dependencies
package asfd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 16;
    localparam int DELTA_W     = 10;
    localparam int ADDR_W      = 8;
    localparam int DUTY_W      = 8;
    localparam int WORD_W      = 16;
    localparam int WORD_IDX_W  = 4;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DELTA_W-1:0] DELTA_RESET    = 10'd200;
    localparam logic [ADDR_W-1:0]  ADDR_RESET     = 8'd2;
    localparam logic [ADDR_W-1:0]  BROADCAST_ADDR = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_DELTA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR  = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_DATA  = 3'b010,
        PH_CHECK = 3'b100
    } frm_phase_t;

    typedef struct packed {
        logic              accepted;
        logic [DUTY_W-1:0] duty;
    } frm_result_t;

endpackage

/* rtl/asfd_slicer.sv */
// adaptive threshold slicer: tracked high and low levels and the midpoint decision
// depends on asfd_pkg
module asfd_slicer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic [asfd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [asfd_pkg::DELTA_W-1:0]   delta,
    output logic                           data_bit
);

    logic [asfd_pkg::LEVEL_W-1:0] high_level_reg;
    logic [asfd_pkg::LEVEL_W-1:0] high_level_next;
    logic [asfd_pkg::LEVEL_W-1:0] low_level_reg;
    logic [asfd_pkg::LEVEL_W-1:0] low_level_next;
    logic [asfd_pkg::LEVEL_W-1:0] sample_ext;
    logic [asfd_pkg::LEVEL_W-1:0] delta_ext;
    logic [asfd_pkg::LEVEL_W-1:0] high_wide;
    logic [asfd_pkg::LEVEL_W-1:0] low_wide;
    logic [asfd_pkg::LEVEL_W:0]   level_sum;
    logic [asfd_pkg::LEVEL_W-1:0] midpoint;

    always_comb begin
        sample_ext = asfd_pkg::LEVEL_W'(sample);
        delta_ext  = asfd_pkg::LEVEL_W'(delta);
        low_wide   = (sample_ext <= low_level_reg) ? sample_ext : low_level_reg;
        high_wide  = (sample_ext > high_level_reg) ? sample_ext : high_level_reg;
        level_sum  = {1'b0, high_wide} + {1'b0, low_wide};
        midpoint   = level_sum[asfd_pkg::LEVEL_W:1];
        data_bit   = (sample_ext < midpoint);
        if (data_bit) begin
            low_level_next  = sample_ext;
            high_level_next = sample_ext + delta_ext;
        end else begin
            high_level_next = sample_ext;
            low_level_next  = sample_ext - delta_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_level_reg <= '0;
            low_level_reg  <= '0;
        end else if (en) begin
            high_level_reg <= high_level_next;
            low_level_reg  <= low_level_next;
        end
    end

endmodule

/* rtl/asfd_framer.sv */
// serial framer: start bit, data word lsb first, check bit, address match and duty register
// depends on asfd_pkg
module asfd_framer #(
    parameter int FRAME_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         data_bit,
    input  logic [asfd_pkg::ADDR_W-1:0]  own_address,
    output asfd_pkg::frm_result_t        result
);

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

    asfd_pkg::frm_phase_t phase_reg;
    asfd_pkg::frm_phase_t phase_next;
    logic [asfd_pkg::WORD_W-1:0]     word_reg;
    logic [asfd_pkg::WORD_W-1:0]     word_next;
    logic [IDX_W-1:0]                bit_idx_reg;
    logic [IDX_W-1:0]                bit_idx_next;
    logic [asfd_pkg::DUTY_W-1:0]     duty_reg;
    logic [asfd_pkg::DUTY_W-1:0]     duty_next;
    logic [asfd_pkg::ADDR_W-1:0]     frame_addr;
    logic [asfd_pkg::WORD_IDX_W-1:0] word_idx;
    logic                            in_range;
    logic                            accepted;

    always_comb begin
        frame_addr   = word_reg[asfd_pkg::WORD_W-1 -: asfd_pkg::ADDR_W];
        word_idx     = asfd_pkg::WORD_IDX_W'(bit_idx_reg);
        in_range     = (32'(bit_idx_reg) < asfd_pkg::WORD_W);
        phase_next   = phase_reg;
        word_next    = word_reg;
        bit_idx_next = bit_idx_reg;
        duty_next    = duty_reg;
        accepted     = 1'b0;
        unique case (phase_reg)
            asfd_pkg::PH_DATA: begin
                if (data_bit && in_range) begin
                    word_next[word_idx] = 1'b1;
                end
                if (bit_idx_reg == LAST_IDX) begin
                    bit_idx_next = '0;
                    phase_next   = asfd_pkg::PH_CHECK;
                end else begin
                    bit_idx_next = IDX_W'(bit_idx_reg + 1'b1);
                end
            end
            asfd_pkg::PH_CHECK: begin
                if ((data_bit != word_reg[0]) &&
                    ((frame_addr == own_address) ||
                     (frame_addr == asfd_pkg::BROADCAST_ADDR))) begin
                    duty_next = word_reg[asfd_pkg::DUTY_W-1:0];
                    accepted  = 1'b1;
                end
                phase_next = asfd_pkg::PH_WAIT;
            end
            default: begin
                if (data_bit) begin
                    phase_next = asfd_pkg::PH_DATA;
                    word_next  = '0;
                end else begin
                    phase_next = asfd_pkg::PH_WAIT;
                end
            end
        endcase
        result.accepted = accepted;
        result.duty     = duty_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= asfd_pkg::PH_WAIT;
            word_reg    <= '0;
            bit_idx_reg <= '0;
            duty_reg    <= '0;
        end else if (en) begin
            phase_reg   <= phase_next;
            word_reg    <= word_next;
            bit_idx_reg <= bit_idx_next;
            duty_reg    <= duty_next;
        end
    end

    a_duty_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(duty_reg))
        else $error("duty register changed without a beat");

    a_accept_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        result.accepted |-> (phase_reg == asfd_pkg::PH_CHECK))
        else $error("frame accepted outside the check bit");

    a_check_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && (phase_reg == asfd_pkg::PH_CHECK)) |=> (phase_reg == asfd_pkg::PH_WAIT))
        else $error("framer did not return to waiting after the check bit");

endmodule

/* rtl/adaptive_slicer_frame_decoder_core.sv */
// Adaptive slicer frame decoder: takes one converter sample per beat and returns one result
// beat per sample: the sliced level, a frame-accepted flag and the current duty byte. A new
// sample is taken every cycle unless the result side stalls; an accepted sample waits in the
// input register and moves on to the result register, one register at the input and one at
// the result. The level tracker and framer update as a sample moves into the result
// register, giving one sample per cycle when not stalled. Configuration (hysteresis delta, own
// address) is to be written only while no beat is in flight; the block does not enforce this.
// depends on asfd_pkg, asfd_slicer, asfd_framer
module adaptive_slicer_frame_decoder_core #(
    parameter int FRAME_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [asfd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [asfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [asfd_pkg::SAMPLE_W-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_sliced_level,
    output logic                               m_frame_accepted,
    output logic [asfd_pkg::DUTY_W-1:0]        m_duty_value
);

    logic [asfd_pkg::DELTA_W-1:0]  delta_reg;
    logic [asfd_pkg::ADDR_W-1:0]   own_addr_reg;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [asfd_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          m_sliced_level_reg;
    logic                          m_frame_accepted_reg;
    logic [asfd_pkg::DUTY_W-1:0]   m_duty_value_reg;
    logic                          advance;
    logic                          s_take;
    logic                          data_bit;
    asfd_pkg::frm_result_t         frm_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg    <= asfd_pkg::DELTA_RESET;
            own_addr_reg <= asfd_pkg::ADDR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                asfd_pkg::REG_DELTA: delta_reg    <= cfg_wdata[asfd_pkg::DELTA_W-1:0];
                asfd_pkg::REG_ADDR:  own_addr_reg <= cfg_wdata[asfd_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || advance;
    assign s_take        = s_valid && s_ready;
    assign in_valid_next = s_take || (in_valid_reg && !advance);
    assign m_valid_next  = advance || (m_valid_reg && !m_ready);

    asfd_slicer u_slicer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .sample   (in_sample_reg),
        .delta    (delta_reg),
        .data_bit (data_bit)
    );

    asfd_framer #(
        .FRAME_BITS (FRAME_BITS)
    ) u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .data_bit    (data_bit),
        .own_address (own_addr_reg),
        .result      (frm_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg <= s_sample;
        end
        if (advance) begin
            m_sliced_level_reg   <= !data_bit;
            m_frame_accepted_reg <= frm_result.accepted;
            m_duty_value_reg     <= frm_result.duty;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sliced_level   = m_sliced_level_reg;
    assign m_frame_accepted = m_frame_accepted_reg;
    assign m_duty_value     = m_duty_value_reg;

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result register empty after a beat moved forward");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are full and stalled");

endmodule

/* dv/adaptive_slicer_frame_decoder_core_tb.sv */
// testbench for adaptive_slicer_frame_decoder_core: drives samples, predicts slicer levels and
// frame decodes in a small scoreboard class, and checks every result beat against it
// depends on asfd_pkg and adaptive_slicer_frame_decoder_core
`timescale 1ns / 100ps

module adaptive_slicer_frame_decoder_core_tb;

    localparam int FRAME_LEN   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_ITEMS   = 2000;
    localparam int PHASE_ITEMS = 250;
    localparam int LVL_W       = asfd_pkg::LEVEL_W;
    localparam int SMP_W       = asfd_pkg::SAMPLE_W;
    localparam int JUNK_W      = asfd_pkg::CFG_DATA_W - asfd_pkg::ADDR_W;

    typedef struct packed {
        logic                  level;
        asfd_pkg::frm_result_t frame;
    } slice_beat_t;

    class slicer_scoreboard;
        logic [LVL_W-1:0]                hi_lvl;
        logic [LVL_W-1:0]                lo_lvl;
        asfd_pkg::frm_phase_t            phase;
        logic [asfd_pkg::WORD_W-1:0]     word;
        logic [4:0]                      bit_idx;
        logic [asfd_pkg::DUTY_W-1:0]     duty;
        logic [asfd_pkg::DELTA_W-1:0]    delta;
        logic [asfd_pkg::ADDR_W-1:0]     own_addr;
        slice_beat_t                     expected_beats[$];
        int                              n_errors;

        function new();
            hi_lvl   = '0;
            lo_lvl   = '0;
            phase    = asfd_pkg::PH_WAIT;
            word     = '0;
            bit_idx  = '0;
            duty     = '0;
            delta    = asfd_pkg::DELTA_RESET;
            own_addr = asfd_pkg::ADDR_RESET;
            n_errors = 0;
        endfunction

        // returns {data bit, new high level, new low level} without touching state
        function logic [2*LVL_W:0] level_step(logic [SMP_W-1:0] s);
            logic [LVL_W-1:0] h;
            logic [LVL_W-1:0] l;
            logic [LVL_W-1:0] sw;
            logic [LVL_W:0]   sum;
            logic             b;
            h  = hi_lvl;
            l  = lo_lvl;
            sw = LVL_W'(s);
            if (sw <= l) l = sw;
            if (sw > h) h = sw;
            sum = {1'b0, h} + {1'b0, l};
            if (sw >= sum[LVL_W:1]) begin
                b = 1'b0;
                h = sw;
                l = sw - LVL_W'(delta);
            end else begin
                b = 1'b1;
                l = sw;
                h = sw + LVL_W'(delta);
            end
            return {b, h, l};
        endfunction

        // random sample that slices to the wanted bit, if one exists
        function logic [SMP_W-1:0] sample_for_bit(logic want);
            logic [SMP_W-1:0]   s;
            logic [2*LVL_W:0]   r;
            int                 start;
            for (int i = 0; i < 12; i++) begin
                s = SMP_W'($urandom_range(0, 1023));
                r = level_step(s);
                if (r[2*LVL_W] == want) return s;
            end
            start = $urandom_range(0, 1023);
            for (int i = 0; i < 1024; i++) begin
                s = SMP_W'(start + i);
                r = level_step(s);
                if (r[2*LVL_W] == want) return s;
            end
            return s;
        endfunction

        function void note_sample(logic [SMP_W-1:0] s);
            logic [2*LVL_W:0] r;
            logic             b;
            slice_beat_t      e;
            r      = level_step(s);
            b      = r[2*LVL_W];
            hi_lvl = r[2*LVL_W-1:LVL_W];
            lo_lvl = r[LVL_W-1:0];
            e.frame.accepted = 1'b0;
            case (phase)
                asfd_pkg::PH_DATA: begin
                    if (b && bit_idx < 16) word[bit_idx[3:0]] = 1'b1;
                    bit_idx = bit_idx + 5'd1;
                    if (bit_idx >= FRAME_LEN || bit_idx == 0) begin
                        bit_idx = '0;
                        phase   = asfd_pkg::PH_CHECK;
                    end
                end
                asfd_pkg::PH_CHECK: begin
                    if (b != word[0] &&
                        (word[15:8] == own_addr ||
                         word[15:8] == asfd_pkg::BROADCAST_ADDR)) begin
                        duty = word[7:0];
                        e.frame.accepted = 1'b1;
                    end
                    phase = asfd_pkg::PH_WAIT;
                end
                default: begin
                    phase = asfd_pkg::PH_WAIT;
                    if (b) begin
                        phase = asfd_pkg::PH_DATA;
                        word  = '0;
                    end
                end
            endcase
            e.level      = ~b;
            e.frame.duty = duty;
            expected_beats.push_back(e);
        endfunction

        task report_mismatch(string msg);
            if (n_errors < 30) $display("mismatch at %0t: %s", $time, msg);
            n_errors++;
        endtask

        task check_beat(logic lvl, logic acc, logic [asfd_pkg::DUTY_W-1:0] d);
            slice_beat_t e;
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            e = expected_beats.pop_front();
            if (lvl !== e.level)
                report_mismatch($sformatf("sliced_level got %b exp %b", lvl, e.level));
            if (acc !== e.frame.accepted)
                report_mismatch($sformatf("frame_accepted got %b exp %b", acc,
                                          e.frame.accepted));
            if (d !== e.frame.duty)
                report_mismatch($sformatf("duty_value got %0d exp %0d", d, e.frame.duty));
        endtask
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_we;
    logic [asfd_pkg::CFG_IDX_W-1:0]    cfg_addr;
    logic [asfd_pkg::CFG_DATA_W-1:0]   cfg_wdata;
    logic                              s_valid;
    logic                              s_ready;
    logic [SMP_W-1:0]                  s_sample;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_sliced_level;
    logic                              m_frame_accepted;
    logic [asfd_pkg::DUTY_W-1:0]       m_duty_value;

    slicer_scoreboard sb;
    int               items_sent;
    bit               no_gaps;
    bit               hold_req;

    adaptive_slicer_frame_decoder_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sliced_level   (m_sliced_level),
        .m_frame_accepted (m_frame_accepted),
        .m_duty_value     (m_duty_value)
    );

    always #10 aclk = ~aclk;

    function int pick_gap();
        int r;
        if (no_gaps || (items_sent / 120) % 4 == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    task send_sample(logic [SMP_W-1:0] s);
        int g;
        s_valid  <= 1'b1;
        s_sample <= s;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(s);
        items_sent++;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task send_bit(logic b);
        send_sample(sb.sample_for_bit(b));
    endtask

    task send_frame(logic [asfd_pkg::ADDR_W-1:0] addr_byte,
                    logic [asfd_pkg::DUTY_W-1:0] duty_byte, bit good);
        logic [asfd_pkg::WORD_W-1:0] w;
        w = {addr_byte, duty_byte};
        while (sb.phase != asfd_pkg::PH_WAIT) send_bit(1'b0);
        repeat ($urandom_range(0, 2)) send_bit(1'b0);
        send_bit(1'b1);
        for (int i = 0; i < FRAME_LEN; i++) send_bit(w[i]);
        send_bit(good ? ~w[0] : w[0]);
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
    endtask

    task apply_settings(logic [asfd_pkg::DELTA_W-1:0] d, logic [asfd_pkg::ADDR_W-1:0] a);
        logic [JUNK_W-1:0] junk;
        junk = JUNK_W'($urandom_range(0, 3));
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= asfd_pkg::REG_DELTA;
        cfg_wdata <= d;
        @(posedge aclk);
        sb.delta  = d;
        cfg_addr  <= asfd_pkg::REG_ADDR;
        // upper bits beyond the address width must be dropped
        cfg_wdata <= {junk, a};
        @(posedge aclk);
        sb.own_addr = a;
        cfg_we    <= 1'b0;
    endtask

    task random_traffic(int n);
        int                          start;
        int                          r;
        logic [asfd_pkg::ADDR_W-1:0] a;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                r = $urandom_range(0, 99);
                if (r < 45) a = sb.own_addr;
                else if (r < 70) a = asfd_pkg::BROADCAST_ADDR;
                else a = asfd_pkg::ADDR_W'($urandom_range(0, 255));
                send_frame(a, asfd_pkg::DUTY_W'($urandom_range(0, 255)),
                           $urandom_range(0, 9) != 0);
            end else begin
                repeat ($urandom_range(1, 8)) send_sample(SMP_W'($urandom_range(0, 1023)));
            end
        end
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall;
        int rx_cycles;
        int r;
        stall     = 0;
        rx_cycles = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (aresetn && m_valid && m_ready)
                sb.check_beat(m_sliced_level, m_frame_accepted, m_duty_value);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 300;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ((rx_cycles / 150) % 4 == 1) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 40);
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("adaptive_slicer_frame_decoder_core test failed");
        $finish;
    end

    initial begin
        logic [asfd_pkg::DELTA_W-1:0] d;
        logic [asfd_pkg::ADDR_W-1:0]  a;
        sb         = new();
        items_sent = 0;
        no_gaps    = 1'b0;
        hold_req   = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= asfd_pkg::REG_DELTA;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sample extremes, then a broadcast frame on reset settings
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1);
        send_sample(10'd1022);
        send_frame(asfd_pkg::BROADCAST_ADDR, 8'hA5, 1'b1);

        for (int p = 0; items_sent < NUM_ITEMS; p++) begin
            case (p % 6)
                0: begin d = '0;                    a = '0;                      end
                1: begin d = '1;                    a = asfd_pkg::BROADCAST_ADDR; end
                2: begin d = asfd_pkg::DELTA_RESET; a = asfd_pkg::ADDR_RESET;     end
                3: begin d = 10'd1;                 a = 8'd254;                  end
                default: begin
                    d = asfd_pkg::DELTA_W'($urandom_range(0, 1023));
                    a = asfd_pkg::ADDR_W'($urandom_range(0, 255));
                end
            endcase
            apply_settings(d, a);
            if (p == 2) begin
                // block fills up while the result side holds off
                no_gaps  = 1'b1;
                hold_req = 1'b1;
            end
            random_traffic(PHASE_ITEMS);
            no_gaps = 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.n_errors == 0 && sb.expected_beats.size() == 0)
            $display("adaptive_slicer_frame_decoder_core test passed");
        else
            $display("adaptive_slicer_frame_decoder_core test failed");
        $finish;
    end

endmodule
